/* src/btpm_pkg.sv */
// shared types and constants for the binary trie prefix match block
// used by btpm_walk and binary_trie_prefix_match; no dependencies
package btpm_pkg;

   localparam int NODES_DEFAULT      = 1024;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int KEY_BITS = 32;
   localparam int LEN_W    = 6;
   localparam int OUT_BITS = 32;

   localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_FIND   = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_BUSY = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [31:0]      entry_value;
      logic [LEN_W-1:0] prefix_len;
      logic [31:0]      key;
      logic [1:0]       opcode;
   } item_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] match_value;
      logic [1:0]          status;
   } result_type;

endpackage

/* src/btpm_node_mem.sv */
// node record memory of the trie: one write port, one registered read port
// no package dependencies
module btpm_node_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 52
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/btpm_walk.sv */
// trie walk sequencer: steps one level per cycle, allocates nodes, sets values
// depends on btpm_pkg; drives the btpm_node_mem ports
module btpm_walk #(
   parameter int NODES      = btpm_pkg::NODES_DEFAULT,
   parameter int VALUE_BITS = btpm_pkg::VALUE_BITS_DEFAULT,
   parameter int IDX_W      = $clog2(NODES),
   parameter int VW         = (VALUE_BITS < 32) ? VALUE_BITS : 32,
   parameter int REC_W      = VW + 2 * IDX_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  btpm_pkg::item_type    item,
   output logic                  res_valid,
   input  logic                  res_ready,
   output btpm_pkg::result_type  res,
   output logic                  mem_we,
   output logic [IDX_W-1:0]      mem_waddr,
   output logic [REC_W-1:0]      mem_wdata,
   output logic [IDX_W-1:0]      mem_raddr,
   input  logic [REC_W-1:0]      mem_rdata
);

   localparam int CNT_W = IDX_W + 1;
   localparam int LW    = btpm_pkg::LEN_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_WALK = 5'b00010,
      ST_GROW = 5'b00100,
      ST_SEAL = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [31:0]      key_ff, key_in;
   logic [LW-1:0]    len_ff, len_in;
   logic [VW-1:0]    val_ff, val_in;
   logic [IDX_W-1:0] node_ff, node_in;
   logic [LW-1:0]    depth_ff, depth_in;
   logic [VW-1:0]    match_ff, match_in;
   logic [1:0]       status_ff, status_in;
   logic [REC_W-1:0] rec_ff, rec_in;
   logic [REC_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0] free_ff, free_in;

   logic [REC_W-1:0] cur;
   logic [IDX_W-1:0] cur_left, cur_right, child, fresh;
   logic [VW-1:0]    cur_val;
   logic             dir, full;
   logic [REC_W-1:0] grow_rec;
   logic [LW-1:0]    depth_inc;
   logic             wr, ins_or_del;
   logic [REC_W-1:0] wr_rec;

   // node 0 is the root, held in flops; others come from the memory read
   assign cur       = (node_ff == '0) ? root_ff : mem_rdata;
   assign cur_left  = cur[IDX_W-1:0];
   assign cur_right = cur[2*IDX_W-1:IDX_W];
   assign cur_val   = cur[REC_W-1:2*IDX_W];
   assign dir       = key_ff[31];
   assign child     = dir ? cur_right : cur_left;
   assign fresh     = free_ff[IDX_W-1:0];
   assign full      = free_ff >= CNT_W'(NODES);
   assign depth_inc = depth_ff + 6'd1;
   assign ins_or_del = (op_ff == btpm_pkg::OP_INSERT) || (op_ff == btpm_pkg::OP_DELETE);

   // pending record with the chosen child pointing at the new node
   always_comb begin
      grow_rec = rec_ff;
      if (dir) begin
         grow_rec[2*IDX_W-1:IDX_W] = fresh;
      end else begin
         grow_rec[IDX_W-1:0] = fresh;
      end
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      len_in     = len_ff;
      val_in     = val_ff;
      node_in    = node_ff;
      depth_in   = depth_ff;
      match_in   = match_ff;
      status_in  = status_ff;
      rec_in     = rec_ff;
      free_in    = free_ff;
      item_ready = 1'b0;
      res_valid  = 1'b0;
      wr         = 1'b0;
      wr_rec     = rec_ff;

      case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               op_in     = item.opcode;
               key_in    = item.key;
               len_in    = (item.prefix_len > btpm_pkg::MAX_LEN) ?
                           btpm_pkg::MAX_LEN : item.prefix_len;
               val_in    = item.entry_value[VW-1:0];
               node_in   = '0;
               depth_in  = '0;
               match_in  = '0;
               status_in = btpm_pkg::STATUS_OK;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            if (op_ff == btpm_pkg::OP_FIND) begin
               if (cur_val != '0) begin
                  match_in = cur_val;
               end
               if ((depth_ff == btpm_pkg::MAX_LEN) || (child == '0)) begin
                  state_in = ST_DONE;
               end else begin
                  node_in  = child;
                  depth_in = depth_inc;
                  key_in   = {key_ff[30:0], 1'b0};
               end
            end else if (ins_or_del) begin
               if ((depth_ff != len_ff) && (child != '0)) begin
                  node_in  = child;
                  depth_in = depth_inc;
                  key_in   = {key_ff[30:0], 1'b0};
               end else if (depth_ff == len_ff) begin
                  state_in = ST_DONE;
                  if (op_ff == btpm_pkg::OP_DELETE) begin
                     wr     = 1'b1;
                     wr_rec = {{VW{1'b0}}, cur[2*IDX_W-1:0]};
                  end else if (cur_val != '0) begin
                     status_in = btpm_pkg::STATUS_BUSY;
                  end else begin
                     wr     = 1'b1;
                     wr_rec = {val_ff, cur[2*IDX_W-1:0]};
                  end
               end else if (op_ff == btpm_pkg::OP_INSERT) begin
                  rec_in   = cur;
                  state_in = ST_GROW;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_GROW: begin
            if (depth_ff == len_ff) begin
               state_in = ST_SEAL;
            end else if (full) begin
               status_in = btpm_pkg::STATUS_FULL;
               state_in  = ST_SEAL;
            end else begin
               wr       = 1'b1;
               wr_rec   = grow_rec;
               rec_in   = {((depth_inc == len_ff) ? val_ff : {VW{1'b0}}),
                           {(2 * IDX_W){1'b0}}};
               node_in  = fresh;
               depth_in = depth_inc;
               key_in   = {key_ff[30:0], 1'b0};
               free_in  = free_ff + CNT_W'(1);
            end
         end
         ST_SEAL: begin
            // last node of the new chain gets its record
            wr       = 1'b1;
            wr_rec   = rec_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // writes to node 0 land in the root flops, others in the memory
   always_comb begin
      root_in   = root_ff;
      mem_we    = 1'b0;
      mem_waddr = node_ff;
      mem_wdata = wr_rec;
      mem_raddr = child;
      if (wr) begin
         if (node_ff == '0) begin
            root_in = wr_rec;
         end else begin
            mem_we = 1'b1;
         end
      end
   end

   assign res.status      = status_ff;
   assign res.match_value = btpm_pkg::OUT_BITS'(match_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         root_ff  <= '0;
         free_ff  <= CNT_W'(1);
      end else begin
         state_ff <= state_in;
         root_ff  <= root_in;
         free_ff  <= free_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      len_ff    <= len_in;
      val_ff    <= val_in;
      node_ff   <= node_in;
      depth_ff  <= depth_in;
      match_ff  <= match_in;
      status_ff <= status_in;
      rec_ff    <= rec_in;
   end

endmodule

/* src/binary_trie_prefix_match.sv */
// top level of the binary trie longest prefix match block
// depends on btpm_pkg, btpm_node_mem and btpm_walk
//
// usage
//   req channel: one transfer is one operation (insert, delete or find) on a
//   32-bit key; insert and delete use the leading prefix_len key bits
//   rsp channel: exactly one transfer per request, carrying status and,
//   for find, the deepest non-zero value on the key's path (zero otherwise)
//   steps: the request is taken, then the walk visits one trie level at a time
//   (up to 33 levels for a find); an insert that needs new nodes creates them
//   one by one, up to a whole 32-level path, and then closes the chain; last,
//   the result is handed to the output register
//   throughput: one request at a time, the next one taken the cycle after the
//   result moves to the output register; the walk visits one node per cycle
//   through one read port
//   reset: the trie is empty (root with no value and no children) and the
//   node pool starts at entry one; no clearing pass is needed
//   stall: a result waits in the output register; the next request may be
//   taken meanwhile, but its result is held inside until the register drains
module binary_trie_prefix_match #(
   parameter int NODES      = btpm_pkg::NODES_DEFAULT,
   parameter int VALUE_BITS = btpm_pkg::VALUE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] opcode, [33:2] key, [39:34] prefix_len, [71:40] entry_value
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [33:2] match_value, [39:34] zero
   output logic [39:0] rsp_tdata
);

   localparam int IDX_W = $clog2(NODES);
   localparam int VW    = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int REC_W = VW + 2 * IDX_W;

   btpm_pkg::item_type   item;
   btpm_pkg::result_type res;
   logic                 res_valid, res_ready;

   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr, mem_raddr;
   logic [REC_W-1:0]     mem_wdata, mem_rdata;

   // output register, parts the walk from the receiver
   logic                 rsp_valid_ff, rsp_valid_in;
   btpm_pkg::result_type rsp_data_ff, rsp_data_in;

   // unpack the request transfer
   assign item.opcode      = req_tdata[1:0];
   assign item.key         = req_tdata[33:2];
   assign item.prefix_len  = req_tdata[39:34];
   assign item.entry_value = req_tdata[71:40];

   btpm_walk #(
      .NODES      (NODES),
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IDX_W),
      .VW         (VW),
      .REC_W      (REC_W)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   // one record per pool node: {value, right child, left child}
   btpm_node_mem #(
      .DEPTH  (NODES),
      .ADDR_W (IDX_W),
      .DATA_W (REC_W)
   ) u_node_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // the register takes a new result when empty or draining this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff.match_value, rsp_data_ff.status};

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for binary_trie_prefix_match: a trie scoreboard predicts every
// response and checks it; depends on btpm_pkg and the block itself
`timescale 1ns / 1ps

module tb;

   // opcode that the block must treat as a no-op
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int HOLD_CYCLES  = 300;   // one long receiver hold-off to back the block up
   localparam int DRAIN_CYCLES = 100;   // idle time after the scoreboard empties
   localparam int CLUSTER_ITEMS = 340;
   localparam int FLOOD_PAIRS   = 45;

   // shadow trie: predicts status and match value for each accepted request
   class trie_scoreboard;
      localparam int POOL  = btpm_pkg::NODES_DEFAULT;
      localparam int IDX_W = $clog2(POOL);
      typedef logic [IDX_W-1:0] node_idx;

      logic [31:0]  root_value;
      node_idx      root_kid [2];
      node_idx      left_kid [POOL];
      node_idx      right_kid [POOL];
      logic [31:0]  node_val [POOL];
      logic [IDX_W:0] next_free;
      btpm_pkg::result_type expected_results [$];
      int           errors;

      function new();
         root_value  = '0;
         root_kid[0] = '0;
         root_kid[1] = '0;
         for (int i = 0; i < POOL; i++) begin
            left_kid[i]  = '0;
            right_kid[i] = '0;
            node_val[i]  = '0;
         end
         next_free = 1;
         errors    = 0;
      endfunction

      // index 0 is the root and never a child, so 0 doubles as null
      function node_idx child(node_idx n, logic dir);
         if (n == 0)
            return root_kid[dir];
         return dir ? right_kid[n] : left_kid[n];
      endfunction

      function void link_child(node_idx n, logic dir, node_idx c);
         if (n == 0)
            root_kid[dir] = c;
         else if (dir)
            right_kid[n] = c;
         else
            left_kid[n] = c;
      endfunction

      function logic [31:0] value_at(node_idx n);
         return (n == 0) ? root_value : node_val[n];
      endfunction

      function void store_value(node_idx n, logic [31:0] v);
         if (n == 0)
            root_value = v;
         else
            node_val[n] = v;
      endfunction

      // follows up to len key bits from the msb; returns the depth reached
      function int unsigned walk_prefix(logic [31:0] key, int unsigned len, output node_idx n);
         int unsigned d;
         node_idx c;
         n = '0;
         d = 0;
         while (d < len) begin
            c = child(n, key[31-d]);
            if (c == 0)
               break;
            n = c;
            d++;
         end
         return d;
      endfunction

      function void note_request(btpm_pkg::item_type it);
         int unsigned len, d;
         node_idx n, c;
         logic [31:0] v;
         btpm_pkg::result_type r;
         len = (it.prefix_len > btpm_pkg::MAX_LEN) ? 32 : int'(it.prefix_len);
         r.status      = btpm_pkg::STATUS_OK;
         r.match_value = '0;
         case (it.opcode)
            btpm_pkg::OP_INSERT: begin
               d = walk_prefix(it.key, len, n);
               if (d == len) begin
                  if (value_at(n) != 0)
                     r.status = btpm_pkg::STATUS_BUSY;
                  else
                     store_value(n, it.entry_value);
               end else begin
                  // build the missing tail; nodes made before the pool runs dry stay
                  while (d < len) begin
                     if (next_free >= POOL) begin
                        r.status = btpm_pkg::STATUS_FULL;
                        break;
                     end
                     c = next_free[IDX_W-1:0];
                     next_free++;
                     left_kid[c]  = '0;
                     right_kid[c] = '0;
                     node_val[c]  = (d + 1 == len) ? it.entry_value : '0;
                     link_child(n, it.key[31-d], c);
                     n = c;
                     d++;
                  end
               end
            end
            btpm_pkg::OP_DELETE: begin
               d = walk_prefix(it.key, len, n);
               if (d == len)
                  store_value(n, '0);
            end
            btpm_pkg::OP_FIND: begin
               n = '0;
               d = 0;
               forever begin
                  v = value_at(n);
                  if (v != 0)
                     r.match_value = v;
                  if (d >= 32)
                     break;
                  n = child(n, it.key[31-d]);
                  if (n == 0)
                     break;
                  d++;
               end
            end
            default: ;
         endcase
         expected_results.push_back(r);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
         errors++;
      endtask

      task check_response(btpm_pkg::result_type got);
         btpm_pkg::result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", got.match_value, '0);
            return;
         end
         want = expected_results.pop_front();
         if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
         if (got.match_value != want.match_value)
            report_mismatch("match_value", got.match_value, want.match_value);
      endtask

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // [1:0] opcode, [33:2] key, [39:34] prefix_len, [71:40] entry_value
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [1:0] status, [33:2] match_value, [39:34] zero
   logic [39:0] rsp_tdata;

   bit idle_on       = 1'b1;   // random gaps on both sides
   bit long_hold_ask = 1'b0;   // asks the receiver for one long hold-off

   logic [31:0] key_bases [4];
   trie_scoreboard sb;

   binary_trie_prefix_match dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // generous ceiling well above the slowest legal run
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off counted here
   initial begin
      int hold;
      bit long_done;
      hold       = 0;
      long_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_ask && !long_done) begin
            long_done = 1'b1;
            hold      = HOLD_CYCLES;
         end
         if (hold > 0) begin
            rsp_tready = 1'b0;
            hold--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            hold       = $urandom_range(0, 9);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // response transfers are checked at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(btpm_pkg::result_type'(rsp_tdata[33:0]));
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_request(input btpm_pkg::item_type it);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid = 1'b0;
         req_tdata  = 72'({$urandom(), $urandom(), $urandom()});
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tdata  = it;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(it);
      @(negedge clock);
   endtask

   task automatic send_op(input logic [1:0] op, input logic [31:0] key,
                          input logic [5:0] len, input logic [31:0] val);
      btpm_pkg::item_type it;
      it.opcode      = op;
      it.key         = key;
      it.prefix_len  = len;
      it.entry_value = val;
      send_request(it);
   endtask

   // keys cluster round a few bases so paths are shared and the pool lasts
   function automatic btpm_pkg::item_type clustered_item();
      btpm_pkg::item_type it;
      int pick;
      logic [31:0] vary;
      case ($urandom_range(0, 7))
         0:       vary = 32'h0;
         1, 2:    vary = 32'hF;
         3, 4:    vary = 32'hFF;
         5:       vary = 32'hFFF;
         6:       vary = 32'hFFFF;
         default: vary = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 32'hFF;
      endcase
      it.key = key_bases[$urandom_range(0, 3)] ^ ($urandom() & vary);
      case ($urandom_range(0, 15))
         0:       it.prefix_len = 6'd0;
         1:       it.prefix_len = 6'($urandom_range(33, 63));
         2, 3:    it.prefix_len = btpm_pkg::MAX_LEN;
         default: it.prefix_len = 6'($urandom_range(1, 32));
      endcase
      case ($urandom_range(0, 7))
         0:       it.entry_value = 32'h0;
         1:       it.entry_value = 32'($urandom_range(1, 15));
         default: it.entry_value = $urandom();
      endcase
      pick = $urandom_range(0, 15);
      if (pick < 6)
         it.opcode = btpm_pkg::OP_INSERT;
      else if (pick < 9)
         it.opcode = btpm_pkg::OP_DELETE;
      else if (pick < 15)
         it.opcode = btpm_pkg::OP_FIND;
      else
         it.opcode = OP_UNUSED;
      return it;
   endfunction

   initial begin
      logic [31:0] k;
      sb         = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty trie, root prefix, extremes, long prefix, zero insert,
      // delete miss, unused opcode
      send_op(btpm_pkg::OP_FIND,   32'h0000_0000, 6'd0,  32'h0);
      send_op(btpm_pkg::OP_INSERT, 32'h0000_0000, 6'd0,  32'h0000_0001);
      send_op(btpm_pkg::OP_FIND,   32'hFFFF_FFFF, 6'd0,  32'h0);
      send_op(btpm_pkg::OP_INSERT, 32'h1234_5678, 6'd0,  32'hAAAA_AAAA);
      send_op(btpm_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
      send_op(btpm_pkg::OP_FIND,   32'hFFFF_FFFF, 6'd0,  32'h0);
      send_op(btpm_pkg::OP_FIND,   32'h7FFF_FFFF, 6'd0,  32'h0);
      send_op(btpm_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd63, 32'h5555_5555);
      send_op(btpm_pkg::OP_INSERT, 32'h8000_0000, 6'd1,  32'h0000_0005);
      send_op(btpm_pkg::OP_FIND,   32'h8000_0001, 6'd0,  32'h0);
      send_op(btpm_pkg::OP_INSERT, 32'h1234_5678, 6'd16, 32'h0);
      send_op(btpm_pkg::OP_FIND,   32'h1234_5678, 6'd0,  32'h0);
      send_op(btpm_pkg::OP_INSERT, 32'h1234_5678, 6'd16, 32'h0000_0007);
      send_op(btpm_pkg::OP_FIND,   32'h1234_FFFF, 6'd0,  32'h0);
      send_op(btpm_pkg::OP_DELETE, 32'h0000_0000, 6'd32, 32'hFFFF_FFFF);
      send_op(btpm_pkg::OP_DELETE, 32'h8000_0000, 6'd1,  32'h0);
      send_op(btpm_pkg::OP_FIND,   32'h8000_0001, 6'd0,  32'h0);
      send_op(btpm_pkg::OP_DELETE, 32'h0000_0000, 6'd0,  32'h0);
      send_op(btpm_pkg::OP_FIND,   32'h0000_0000, 6'd0,  32'h0);
      send_op(OP_UNUSED,           32'hDEAD_BEEF, 6'd63, 32'hFFFF_FFFF);
      send_op(btpm_pkg::OP_DELETE, 32'hFFFF_FFFF, 6'd40, 32'h0);
      send_op(btpm_pkg::OP_FIND,   32'hFFFF_FFFF, 6'd0,  32'h0);

      for (int i = 0; i < 4; i++)
         key_bases[i] = $urandom();

      // clustered random traffic; the long hold-off lands early, and one
      // stretch in the middle runs with no gaps
      long_hold_ask = 1'b1;
      for (int i = 0; i < CLUSTER_ITEMS; i++) begin
         idle_on = !(i >= 150 && i < 200);
         send_request(clustered_item());
      end

      // last part, no gaps: long random inserts drain the node pool, with
      // finds beside them so deep paths and the full status are both seen
      idle_on = 1'b0;
      for (int i = 0; i < FLOOD_PAIRS; i++) begin
         k = $urandom();
         send_op(btpm_pkg::OP_INSERT, k, btpm_pkg::MAX_LEN, $urandom() | 32'h1);
         send_op(btpm_pkg::OP_FIND, k ^ ($urandom() & 32'hFF),
                 6'($urandom_range(0, 63)), $urandom());
      end
      req_tvalid = 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* files.f */
src/btpm_pkg.sv
src/btpm_node_mem.sv
src/btpm_walk.sv
src/binary_trie_prefix_match.sv
tb/sv/tb.sv
